FILE: hw/rtl/dpad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpad_pkg: shared types and constants for the DMX phase-angle dimmer
// Beat payload structs, opcode and register codes, reset values.
// ----------------------------------------------------------------------------
package dpad_pkg;

    // Fixed field widths
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned WORD_W   = 9;
    localparam int unsigned GATE_W   = 6;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_WORD       = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ZERO_CROSS = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK       = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_ZC_DELAY    = 2'd0;
    localparam logic [1:0] REG_STEP_PERIOD = 2'd1;
    localparam logic [1:0] REG_PULSE_WIDTH = 2'd2;

    // Register reset values
    localparam logic [TIMER_W-1:0] ZC_DELAY_RST    = 16'd1248;
    localparam logic [TIMER_W-1:0] STEP_PERIOD_RST = 16'd18;
    localparam logic [TIMER_W-1:0] PULSE_WIDTH_RST = 16'd7;

    localparam logic [LEVEL_W-1:0] PHASE_START = 8'd255;
    localparam int unsigned        DATA_MARK_BIT = 8;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [WORD_W-1:0]   rx_word;
        logic                framing_error;
    } dpad_item_t;

    typedef struct packed {
        logic [GATE_W-1:0] gate_bits;
        logic              phase_running;
        logic [SLOT_W-1:0] slot_index;
    } dpad_result_t;

endpackage

FILE: hw/rtl/dmx_phase_angle_dimmer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_phase_angle_dimmer: DMX512 slot decoder and phase-angle gate timer
// An accepted item beat passes the input register, then the result register,
// to become its result beat; result_stall can hold it between the two.
// Throughput: one item per cycle while result_stall does not hold; the single-pass
// state update between the two registers is what sets this figure.
// Reset (rst_n low, async): slot position, phase count, timers, flags, gates and
// channel levels clear; registers return to 1248 / 18 / 7.
// ----------------------------------------------------------------------------
module dmx_phase_angle_dimmer
    import dpad_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS   = 6,
    parameter int unsigned UNIVERSE_SLOTS = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  dpad_item_t          item,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output dpad_result_t        result,
    // APB-style register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // Slot position needs to hold UNIVERSE_SLOTS itself (saturated value).
    localparam int unsigned POS_W = $clog2(UNIVERSE_SLOTS + 1);
    // Gate vector widened so the visible six bits can always be selected.
    localparam int unsigned GW    = (NUM_CHANNELS > GATE_W) ? NUM_CHANNELS : GATE_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(UNIVERSE_SLOTS);

    // ------------------------------------------------------------------------
    // Register file. Writes must only arrive while the block is idle; the block does not enforce it.
    // ------------------------------------------------------------------------
    logic [TIMER_W-1:0] zc_delay_reg;
    logic [TIMER_W-1:0] step_period_reg;
    logic [TIMER_W-1:0] pulse_width_reg;
    logic               cfg_write;
    logic [1:0]         cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zc_delay_reg    <= ZC_DELAY_RST;
            step_period_reg <= STEP_PERIOD_RST;
            pulse_width_reg <= PULSE_WIDTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ZC_DELAY:    zc_delay_reg    <= pwdata[TIMER_W-1:0];
                REG_STEP_PERIOD: step_period_reg <= pwdata[TIMER_W-1:0];
                REG_PULSE_WIDTH: pulse_width_reg <= pwdata[TIMER_W-1:0];
                default:         ;  // unmapped: write ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_ZC_DELAY:    prdata = APB_DW'(zc_delay_reg);
            REG_STEP_PERIOD: prdata = APB_DW'(step_period_reg);
            REG_PULSE_WIDTH: prdata = APB_DW'(pulse_width_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Beat flow: input register -> single-pass update -> result register.
    // The result register frees up whenever it is empty or being taken, so a
    // new item enters every cycle unless the result side stalls.
    // ------------------------------------------------------------------------
    logic         in_valid_reg;
    dpad_item_t   in_reg;
    logic         result_valid_reg;
    dpad_result_t result_reg;
    dpad_result_t result_next;
    logic         out_free;
    logic         advance;
    logic         accept;

    assign out_free     = !result_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_free;
    assign item_stall   = in_valid_reg && !out_free;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------------
    // Dimmer state
    // ------------------------------------------------------------------------
    logic [LEVEL_W-1:0]      level_reg [NUM_CHANNELS];
    logic [POS_W-1:0]        pos_reg,         pos_next;
    logic [LEVEL_W-1:0]      phase_reg,       phase_next;
    logic [TIMER_W-1:0]      step_timer_reg,  step_timer_next;
    logic [TIMER_W-1:0]      pulse_timer_reg, pulse_timer_next;
    logic                    running_reg,     running_next;
    logic                    pulse_reg,       pulse_next;
    logic [NUM_CHANNELS-1:0] gate_reg,        gate_next;
    logic [NUM_CHANNELS-1:0] level_match;
    logic [NUM_CHANNELS-1:0] level_we;
    logic [GW-1:0]           gate_wide;
    logic                    data_ok;

    // Gates whose level equals the current countdown value.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            level_match[ch] = (level_reg[ch] == phase_reg);
        end
    end

    // A data word that is actually stored and advances the position.
    assign data_ok = (in_reg.opcode == OP_WORD) && !in_reg.framing_error
                     && in_reg.rx_word[DATA_MARK_BIT] && (pos_reg < POS_MAX);

    // Slot n (1..NUM_CHANNELS) lands in channel n-1.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            level_we[ch] = data_ok && (SLOT_W'(pos_reg) == SLOT_W'(ch + 1));
        end
    end

    always_comb
    begin
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        step_timer_next  = step_timer_reg;
        pulse_timer_next = pulse_timer_reg;
        running_next     = running_reg;
        pulse_next       = pulse_reg;
        gate_next        = gate_reg;

        unique case (in_reg.opcode)
            OP_WORD:
            begin
                // break or non-data word restarts the frame
                if (in_reg.framing_error || !in_reg.rx_word[DATA_MARK_BIT])
                begin
                    pos_next = '0;
                end
                else if (data_ok)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            OP_ZERO_CROSS:
            begin
                phase_next      = PHASE_START;
                running_next    = 1'b1;
                step_timer_next = zc_delay_reg;
            end
            OP_TICK:
            begin
                // pulse timer first: expiry drops every gate
                if (pulse_reg)
                begin
                    if (pulse_timer_reg <= TIMER_W'(1))
                    begin
                        pulse_timer_next = '0;
                        pulse_next       = 1'b0;
                        gate_next        = '0;
                    end
                    else
                    begin
                        pulse_timer_next = pulse_timer_reg - TIMER_W'(1);
                    end
                end
                // then the phase step timer
                if (running_reg)
                begin
                    if (step_timer_reg <= TIMER_W'(1))
                    begin
                        gate_next        = gate_next | level_match;
                        pulse_next       = 1'b1;
                        pulse_timer_next = pulse_width_reg;
                        step_timer_next  = step_period_reg;
                        phase_next       = phase_reg - LEVEL_W'(1);
                        if (phase_next == '0)
                        begin
                            running_next = 1'b0;
                        end
                    end
                    else
                    begin
                        step_timer_next = step_timer_reg - TIMER_W'(1);
                    end
                end
            end
            default: ;  // unused opcode: state holds, result reports it
        endcase

        gate_wide                 = GW'(gate_next);
        result_next.gate_bits     = gate_wide[GATE_W-1:0];
        result_next.phase_running = running_next;
        result_next.slot_index    = SLOT_W'(pos_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            phase_reg       <= '0;
            step_timer_reg  <= '0;
            pulse_timer_reg <= '0;
            running_reg     <= 1'b0;
            pulse_reg       <= 1'b0;
            gate_reg        <= '0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                level_reg[ch] <= '0;
            end
        end
        else if (advance)
        begin
            pos_reg         <= pos_next;
            phase_reg       <= phase_next;
            step_timer_reg  <= step_timer_next;
            pulse_timer_reg <= pulse_timer_next;
            running_reg     <= running_next;
            pulse_reg       <= pulse_next;
            gate_reg        <= gate_next;
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                if (level_we[ch])
                begin
                    level_reg[ch] <= in_reg.rx_word[LEVEL_W-1:0];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/dpad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpad_checker: port-level assertions for the DMX phase-angle dimmer
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
module dpad_checker
    import dpad_pkg::*;
#(
    parameter int unsigned UNIVERSE_SLOTS = 512
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input dpad_item_t        item,
    input logic              result_valid,
    input logic              result_stall,
    input dpad_result_t      result
);

    logic item_take;
    assign item_take = item_valid && !item_stall;

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // slot position saturates at the universe size
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.slot_index <= 10'(UNIVERSE_SLOTS)))
        else $error("slot index beyond universe");

    // zero-cross starts the countdown, seen on its result beat when result_stall is low after the take
    a_zc_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.opcode == OP_ZERO_CROSS) ##1 !result_stall
        |=> result_valid && result.phase_running)
        else $error("zero-cross did not start phase countdown");

    // a broken word returns the slot position to zero
    a_break_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item.opcode == OP_WORD && item.framing_error) ##1 !result_stall
        |=> result_valid && result.slot_index == '0)
        else $error("framing error did not reset slot index");

endmodule

bind dmx_phase_angle_dimmer dpad_checker #(.UNIVERSE_SLOTS(UNIVERSE_SLOTS)) u_dpad_checker (.*);
